[hdl/hcbp_pkg.sv]
package hcbp_pkg;

  // default configuration
  localparam int unsigned MAX_CODE_LEN_DEF = 32;
  localparam int unsigned NUM_SYMBOLS_DEF  = 256;

  // field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BC_W   = 4;

  // item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_e;

  // input item
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_len;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic table_write;
    logic table_read;
    logic load_code;
    logic step;
    logic flush_emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_zero;
    logic byte_full;
    logic bc_zero;
    logic out_free;
  } dp_status_t;

endpackage

[hdl/huffman_code_bit_packer.sv]
// Huffman code bit packer: holds a table of NUM_SYMBOLS codes (up to 32 bits each,
// cleared to length zero by reset) and packs the code of each encoded symbol LSB
// first into bytes. Opcode 0 loads a table entry, 1 encodes a symbol, 2 flushes the
// partial byte; a full byte is held until the next bit arrives, and the last byte
// caused by an item is marked with last. The input is taken only between items.
// A load writes the table entry. An encode reads the entry through the registered
// table read port, loads the code into the shift register, then takes a packing
// step per byte segment through the shift register. A flush emits the pending byte
// if there is one. A byte that must leave while the output register is still stalled
// holds the packing step or the flush until the register is free.
module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int unsigned NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  hcbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // table, packer and output register
  hcbp_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/hcbp_ram.sv]
module hcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/hcbp_datapath.sv]
module hcbp_datapath import hcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int unsigned NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  ctrl_cmd_t  cmd_i,
  input  logic       out_stall_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  localparam int unsigned LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int unsigned ADDR_W  = $clog2(NUM_SYMBOLS);
  localparam int unsigned ENTRY_W = LEN_W + CODE_W;
  localparam logic [SYM_W:0]  SYM_LIMIT = (SYM_W+1)'(NUM_SYMBOLS);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LEN_CAP);
  localparam logic [BC_W-1:0]  BC_FULL  = BC_W'(BYTE_W);

  logic              sym_ok;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  len_sat;
  logic [ENTRY_W-1:0] wr_entry, rd_entry;
  logic [NUM_SYMBOLS-1:0] vld_q;
  logic              hit_q;

  logic [BYTE_W-1:0] pend_q, pend_d;
  logic [BC_W-1:0]   bc_q, bc_d;
  logic [CODE_W-1:0] sh_q, sh_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              full, emit, out_free;
  logic [BC_W-1:0]   base_bc, space, k;
  logic [BYTE_W-1:0] base_pend, mask;
  logic [BYTE_W:0]   mask_w;
  logic [2*BYTE_W-1:0] ins;

  // table access; bits above the length are never sent, so they are kept as written
  assign sym_ok   = {1'b0, in_data_i.symbol} < SYM_LIMIT;
  assign addr     = in_data_i.symbol[ADDR_W-1:0];
  assign len_sat  = (in_data_i.code_len > LEN_MAX) ? LEN_MAX : in_data_i.code_len;
  assign wr_entry = {len_sat, in_data_i.code_bits};

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.table_write && sym_ok),
    .waddr_i (addr),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.table_read),
    .raddr_i (addr),
    .rdata_o (rd_entry)
  );

  // per-entry valid bits: an unwritten entry reads as length zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cmd_i.table_write && sym_ok) begin
        vld_q[addr] <= 1'b1;
      end
      if (cmd_i.table_read) begin
        hit_q <= sym_ok && vld_q[addr];
      end
    end
  end

  // one packing step: drop a full byte, then add as many bits as fit
  always_comb begin
    full      = (bc_q == BC_FULL);
    base_bc   = full ? '0 : bc_q;
    base_pend = full ? '0 : pend_q;
    space     = BC_FULL - base_bc;
    k         = ({{(LEN_W-BC_W){1'b0}}, space} < rem_q) ? space : rem_q[BC_W-1:0];
    mask_w    = ((BYTE_W+1)'(1) << k) - (BYTE_W+1)'(1);
    mask      = mask_w[BYTE_W-1:0];
    ins       = {{BYTE_W{1'b0}}, sh_q[BYTE_W-1:0] & mask} << base_bc;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (cmd_i.step && full) || cmd_i.flush_emit;

  // packer and code shift register
  always_comb begin
    pend_d = pend_q;
    bc_d   = bc_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (cmd_i.load_code) begin
      rem_d = hit_q ? rd_entry[ENTRY_W-1 -: LEN_W] : '0;
      sh_d  = rd_entry[CODE_W-1:0];
    end else if (cmd_i.step) begin
      pend_d = base_pend | ins[BYTE_W-1:0];
      bc_d   = base_bc + k;
      sh_d   = sh_q >> k;
      rem_d  = rem_q - {{(LEN_W-BC_W){1'b0}}, k};
    end else if (cmd_i.flush_emit) begin
      pend_d = '0;
      bc_d   = '0;
    end
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_d.out_byte = pend_q;
      out_d.last     = cmd_i.flush_emit || (rem_q <= LEN_W'(BYTE_W));
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      bc_q        <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      bc_q        <= bc_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    out_q <= out_d;
  end

  assign status_o.rem_zero  = (rem_q == '0);
  assign status_o.byte_full = full;
  assign status_o.bc_zero   = (bc_q == '0);
  assign status_o.out_free  = out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_bc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= BC_FULL)
    else $error("bit count beyond one byte");

  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("byte emitted while output register is occupied");

  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && (rem_q != '0)) |=> (rem_q < $past(rem_q)))
    else $error("packing step made no progress");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && full && (rem_q <= LEN_W'(BYTE_W))) |=> (rem_q == '0))
    else $error("byte marked last but code bits remain");

endmodule

[hdl/hcbp_ctrl.sv]
module hcbp_ctrl import hcbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_item_t   in_data_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // sequencing of one item
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.opcode)
            OP_LOAD:   cmd_o.table_write = 1'b1;
            OP_ENCODE: begin
              cmd_o.table_read = 1'b1;
              state_d          = ST_LOOKUP;
            end
            OP_FLUSH:  state_d = ST_FLUSH;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        cmd_o.load_code = 1'b1;
        state_d         = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.rem_zero) begin
          state_d = ST_IDLE;
        end else if (!status_i.byte_full || status_i.out_free) begin
          cmd_o.step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (status_i.bc_zero) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush_emit = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  a_lookup_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |-> $past(cmd_o.table_read))
    else $error("code loaded without a table read");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_lookup_to_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) |=> (state_q == ST_RUN))
    else $error("lookup not followed by packing");

endmodule

[tb/hcbp_checker.sv]
// watches both channels of the bit packer, predicts the packed bytes and compares
module hcbp_checker import hcbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  output int unsigned fail_cnt_o,
  output int unsigned open_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LenCap = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;

  // predictor state: code table and packing byte
  logic [LEN_W-1:0]  code_len_tbl  [NUM_SYMBOLS_DEF];
  logic [CODE_W-1:0] code_bits_tbl [NUM_SYMBOLS_DEF];
  logic [BYTE_W-1:0] pack_byte;
  logic [BC_W-1:0]   pack_cnt;

  // packed bytes still owed by the block, oldest first
  out_item_t   byte_q[$];
  int unsigned fail_cnt;

  assign fail_cnt_o = fail_cnt;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // apply one input item to the predictor and queue the bytes it releases
  task automatic predict_item(input in_item_t item);
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] bits;
    out_item_t         res;
    out_item_t         new_q[$];
    case (item.opcode)
      OP_LOAD: begin
        len  = item.code_len;
        bits = item.code_bits;
        if (int'(len) > LenCap) len = LenCap[LEN_W-1:0];
        if (len < CODE_W) bits &= (32'h1 << len) - 32'h1;
        code_len_tbl[item.symbol]  = len;
        code_bits_tbl[item.symbol] = bits;
      end
      OP_ENCODE: begin
        len  = code_len_tbl[item.symbol];
        bits = code_bits_tbl[item.symbol];
        for (int i = 0; i < int'(len); i++) begin
          // a full byte leaves only when the next bit shows up
          if (pack_cnt >= BYTE_W) begin
            res.out_byte = pack_byte;
            res.last     = 1'b0;
            new_q.push_back(res);
            pack_byte = '0;
            pack_cnt  = '0;
          end
          if (bits[i]) pack_byte[pack_cnt[2:0]] = 1'b1;
          pack_cnt++;
        end
        if (new_q.size() > 0) new_q[new_q.size()-1].last = 1'b1;
        foreach (new_q[k]) byte_q.push_back(new_q[k]);
      end
      OP_FLUSH: begin
        if (pack_cnt != 0) begin
          res.out_byte = pack_byte;
          res.last     = 1'b1;
          byte_q.push_back(res);
          pack_byte = '0;
          pack_cnt  = '0;
        end
      end
      default: ;
    endcase
  endtask

  // compare accepted bytes first, then fold in the accepted input item
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SYMBOLS_DEF; k++) begin
        code_len_tbl[k]  = '0;
        code_bits_tbl[k] = '0;
      end
      pack_byte = '0;
      pack_cnt  = '0;
      byte_q.delete();
      fail_cnt   = 0;
      open_cnt_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0d",
                                    out_data_i.out_byte, out_data_i.last));
        end else begin
          want = byte_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                      out_data_i.out_byte, want.out_byte));
          if (out_data_i.last !== want.last)
            report_mismatch($sformatf("last %0d, predicted %0d on byte %02h",
                                      out_data_i.last, want.last, want.out_byte));
        end
      end
      if (in_valid_i && !in_stall_i) predict_item(in_data_i);
      open_cnt_o <= byte_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// stimulus and verdict for the bit packer; checking lives in hcbp_checker
module tb_top import hcbp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned PhaseItems = 39;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  int unsigned fail_cnt;
  int unsigned open_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  huffman_code_bit_packer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  hcbp_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_cnt_o  (fail_cnt),
    .open_cnt_o  (open_cnt)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver back-pressure and run watchdog
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_item_t mk_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                       input logic [CODE_W-1:0] bits,
                                       input logic [LEN_W-1:0] len);
    in_item_t item;
    item.opcode    = op;
    item.symbol    = sym;
    item.code_bits = bits;
    item.code_len  = len;
    return item;
  endfunction

  // one transfer on the input channel, with random idle cycles ahead of it
  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // random item: mostly encodes from a small pool of loaded symbols
  function automatic in_item_t rand_item();
    int unsigned       pick;
    int unsigned       lsel;
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    pick = $urandom_range(0, 99);
    sym  = ($urandom_range(0, 9) < 8) ? SYM_W'($urandom_range(0, 15))
                                      : SYM_W'($urandom_range(0, 255));
    lsel = $urandom_range(0, 19);
    if (lsel == 0) len = '0;
    else if (lsel == 1) len = LEN_W'(32);
    else if (lsel == 2) len = LEN_W'($urandom_range(33, 63));
    else if (lsel < 6) len = LEN_W'($urandom_range(13, 31));
    else len = LEN_W'($urandom_range(1, 12));
    if (pick < 18) return mk_item(OP_LOAD, sym, $urandom, len);
    else if (pick < 85) return mk_item(OP_ENCODE, sym, $urandom, len);
    else if (pick < 95) return mk_item(OP_FLUSH, sym, $urandom, len);
    else return mk_item(OP_UNUSED, sym, $urandom, len);
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: empty table, empty packer and ignored opcode
    send_item(mk_item(OP_ENCODE, 8'd0, '0, '0));
    send_item(mk_item(OP_FLUSH, 8'd0, '0, '0));
    send_item(mk_item(OP_UNUSED, 8'hff, 32'hffff_ffff, 6'd63));
    // loads: full length, overlong, bits above length, exact byte, no code
    send_item(mk_item(OP_LOAD, 8'd1, 32'hffff_ffff, 6'd32));
    send_item(mk_item(OP_LOAD, 8'd2, 32'ha5a5_5a5a, 6'd63));
    send_item(mk_item(OP_LOAD, 8'hff, 32'hffff_fffe, 6'd1));
    send_item(mk_item(OP_LOAD, 8'd3, 32'h0000_00c3, 6'd8));
    send_item(mk_item(OP_LOAD, 8'd4, 32'hffff_ffff, 6'd5));
    send_item(mk_item(OP_LOAD, 8'd0, 32'hffff_ffff, 6'd0));
    // full byte held until the next bit, then a partial flush
    send_item(mk_item(OP_ENCODE, 8'd3, '0, '0));
    send_item(mk_item(OP_ENCODE, 8'hff, '0, '0));
    send_item(mk_item(OP_FLUSH, 8'd0, '0, '0));
    // 32-bit codes release three and then four bytes
    send_item(mk_item(OP_ENCODE, 8'd1, '0, '0));
    send_item(mk_item(OP_ENCODE, 8'd1, '0, '0));
    send_item(mk_item(OP_ENCODE, 8'd2, '0, '0));
    send_item(mk_item(OP_FLUSH, 8'd0, '0, '0));
    send_item(mk_item(OP_FLUSH, 8'd0, '0, '0));
    send_item(mk_item(OP_ENCODE, 8'd0, '0, '0));
    send_item(mk_item(OP_ENCODE, 8'd4, '0, '0));
    send_item(mk_item(OP_ENCODE, 8'hff, '0, '0));
    send_item(mk_item(OP_FLUSH, 8'd0, '0, '0));
    // reload an entry to no code
    send_item(mk_item(OP_LOAD, 8'd1, 32'h0, 6'd0));
    send_item(mk_item(OP_ENCODE, 8'd1, '0, '0));
    send_item(mk_item(OP_FLUSH, 8'd0, '0, '0));

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 66; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 66; end
        default: begin idle_pct = 23; stall_pct <= 23; end
      endcase
      for (int n = 0; n < PhaseItems; n++) send_item(rand_item());
    end
    in_valid <= 1'b0;

    // drain outstanding bytes, then give the block time to show stray output
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
